### rtl/core/tfc_pkg.sv
`timescale 1ns / 1ps

package tfc_pkg;

	// field widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned ERPM_W  = 32;
	localparam int unsigned COUNT_W = 16;

	// number of frame bytes that carry the telemetry fields
	localparam int unsigned FIELD_BYTES = 16;

	// defaults for the top level
	localparam int unsigned FRAME_BYTES_DEFAULT = 20;
	localparam logic [COUNT_W-1:0] FAIL_LIMIT_RESET = COUNT_W'(1000);

endpackage

### rtl/core/tfc_rx_if.sv
`timescale 1ns / 1ps

// byte request channel
interface tfc_rx_if import tfc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_value;
	logic              frame_start;

	modport source (output valid, output byte_value, output frame_start, input ready);
	modport sink   (input valid, input byte_value, input frame_start, output ready);
endinterface

### rtl/core/tfc_res_if.sv
`timescale 1ns / 1ps

// frame result channel
interface tfc_res_if import tfc_pkg::*;;
	logic               valid;
	logic               ready;
	logic               check_ok;
	logic [WORD_W-1:0]  voltage_raw;
	logic [WORD_W-1:0]  temperature_raw;
	logic [WORD_W-1:0]  current_raw;
	logic [ERPM_W-1:0]  erpm_raw;
	logic [WORD_W-1:0]  input_pwm_raw;
	logic [WORD_W-1:0]  output_pwm_raw;
	logic [COUNT_W-1:0] fail_count;
	logic               resync_request;

	modport source (
		output valid, output check_ok, output voltage_raw, output temperature_raw,
		output current_raw, output erpm_raw, output input_pwm_raw,
		output output_pwm_raw, output fail_count, output resync_request,
		input ready
	);
	modport sink (
		input valid, input check_ok, input voltage_raw, input temperature_raw,
		input current_raw, input erpm_raw, input input_pwm_raw,
		input output_pwm_raw, input fail_count, input resync_request,
		output ready
	);
endinterface

### rtl/core/tfc_cfg_if.sv
`timescale 1ns / 1ps

// fail limit write channel
interface tfc_cfg_if import tfc_pkg::*;;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/telemetry_frame_fletcher_checker.sv
`timescale 1ns / 1ps
// a byte request is registered in the input register and worked on from there; the result
// of a frame's last byte is registered on res as that byte leaves the input register
// throughput: one byte per cycle; a frame's last byte waits in the input register
// only while the previous result has not been taken
// reset: arst_n clears position, sums, counter, frame state and fail limit (to 1000)
// at once; the sixteen field byte registers are not reset

module telemetry_frame_fletcher_checker import tfc_pkg::*; #(
	parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	tfc_rx_if.sink    rx,
	tfc_res_if.source res,
	tfc_cfg_if.sink   cfg
);

	localparam int unsigned POS_W = $clog2(FRAME_BYTES);
	localparam logic [POS_W-1:0] POS_CHECK_LO = POS_W'(FRAME_BYTES - 2);
	localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] POS_FIELDS   = POS_W'(FIELD_BYTES);

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              start_s1;

	// frame state
	logic [POS_W-1:0]   pos_q;
	logic [BYTE_W-1:0]  sum1_q;
	logic [BYTE_W-1:0]  sum2_q;
	logic [BYTE_W-1:0]  check_lo_q;
	logic [COUNT_W-1:0] fail_cnt_q;
	logic [COUNT_W-1:0] fail_limit_q;
	logic               active_q;
	logic [BYTE_W-1:0]  field_q [FIELD_BYTES];

	// result register
	logic               res_valid_q;

	// working values for the byte in the input register
	logic               act_eff;
	logic [POS_W-1:0]   pos_eff;
	logic [BYTE_W-1:0]  sum1_eff;
	logic [BYTE_W-1:0]  sum2_eff;
	logic [BYTE_W-1:0]  sum1_nxt;
	logic [BYTE_W-1:0]  sum2_nxt;
	logic [BYTE_W-1:0]  chk_hi;
	logic [BYTE_W-1:0]  chk_lo;
	logic               chk_ok;
	logic [COUNT_W:0]   fail_inc;
	logic               wrap;
	logic               is_last;
	logic               advance;

	always_comb begin
		act_eff  = start_s1 | active_q;
		pos_eff  = start_s1 ? '0 : pos_q;
		sum1_eff = start_s1 ? '0 : sum1_q;
		sum2_eff = start_s1 ? '0 : sum2_q;
		sum1_nxt = sum1_eff + byte_s1;
		sum2_nxt = sum2_eff + sum1_nxt;
		// check word from the sums over the payload
		chk_hi   = sum1_eff - sum2_eff;
		chk_lo   = sum2_eff - {sum1_eff[BYTE_W-2:0], 1'b0};
		chk_ok   = (chk_hi == byte_s1) && (chk_lo == check_lo_q);
		fail_inc = {1'b0, fail_cnt_q} + (COUNT_W+1)'(1);
		wrap     = fail_inc >= {1'b0, fail_limit_q};
		is_last  = act_eff && (pos_eff == POS_LAST);
	end

	// a byte that finishes a frame needs room in the result register
	assign advance  = valid_s1 && (!is_last || !res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1  <= rx.byte_value;
			start_s1 <= rx.frame_start;
		end
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			sum1_q       <= '0;
			sum2_q       <= '0;
			check_lo_q   <= '0;
			fail_cnt_q   <= '0;
			active_q     <= 1'b0;
			fail_limit_q <= FAIL_LIMIT_RESET;
		end else begin
			if (cfg.valid) begin
				fail_limit_q <= cfg.data;
			end
			if (advance && act_eff) begin
				if (pos_eff < POS_CHECK_LO) begin
					sum1_q   <= sum1_nxt;
					sum2_q   <= sum2_nxt;
					pos_q    <= pos_eff + POS_W'(1);
					active_q <= 1'b1;
				end else if (pos_eff == POS_CHECK_LO) begin
					check_lo_q <= byte_s1;
					pos_q      <= pos_eff + POS_W'(1);
					active_q   <= 1'b1;
				end else begin
					pos_q    <= '0;
					active_q <= 1'b0;
					if (!chk_ok) begin
						fail_cnt_q <= wrap ? '0 : fail_inc[COUNT_W-1:0];
					end
				end
			end
		end
	end

	// field byte capture
	always_ff @(posedge clk) begin
		if (advance && act_eff && (pos_eff < POS_FIELDS)) begin
			field_q[pos_eff[$clog2(FIELD_BYTES)-1:0]] <= byte_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && is_last) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_last) begin
			res.check_ok        <= chk_ok;
			res.voltage_raw     <= {field_q[1], field_q[0]};
			res.temperature_raw <= {field_q[3], field_q[2]};
			res.current_raw     <= {field_q[5], field_q[4]};
			res.erpm_raw        <= {field_q[11], field_q[10], field_q[9], field_q[8]};
			res.input_pwm_raw   <= {field_q[13], field_q[12]};
			res.output_pwm_raw  <= {field_q[15], field_q[14]};
			res.fail_count      <= chk_ok ? fail_cnt_q :
				(wrap ? '0 : fail_inc[COUNT_W-1:0]);
			res.resync_request  <= !chk_ok && wrap;
		end
	end

	assign res.valid = res_valid_q;

endmodule

### rtl/core/tfc_checker.sv
`timescale 1ns / 1ps

module tfc_checker import tfc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic               res_check_ok,
	input logic [COUNT_W-1:0] res_fail_count,
	input logic               res_resync_request
);

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its count
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_fail_count))
		else $error("fail count changed while stalled");

	// resync only on a failing frame, with the counter wrapped
	a_resync_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_resync_request |-> !res_check_ok && (res_fail_count == '0))
		else $error("resync without failure and wrap");

	// a failing frame without wrap has counted at least once
	a_fail_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_check_ok && !res_resync_request |-> res_fail_count != '0)
		else $error("failure not counted");

endmodule

bind telemetry_frame_fletcher_checker tfc_checker u_tfc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_check_ok       (res.check_ok),
	.res_fail_count     (res.fail_count),
	.res_resync_request (res.resync_request)
);

### tb/telemetry_frame_fletcher_checker_tb.sv
`timescale 1ns / 1ps

module telemetry_frame_fletcher_checker_tb;
	import tfc_pkg::*;

	localparam int unsigned FRAME_BYTES = FRAME_BYTES_DEFAULT;
	localparam int unsigned CHECK_POS   = FRAME_BYTES - 2;
	localparam int unsigned HOLD_CYCLES = 400;

	// one frame report as it leaves the block
	typedef struct packed {
		logic               check_ok;
		logic [WORD_W-1:0]  voltage_raw;
		logic [WORD_W-1:0]  temperature_raw;
		logic [WORD_W-1:0]  current_raw;
		logic [ERPM_W-1:0]  erpm_raw;
		logic [WORD_W-1:0]  input_pwm_raw;
		logic [WORD_W-1:0]  output_pwm_raw;
		logic [COUNT_W-1:0] fail_count;
		logic               resync_request;
	} frame_report_t;

	typedef enum logic [2:0] {ROW_STRAY, ROW_GOOD, ROW_BAD, ROW_CUT, ROW_LIMIT} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic [15:0]   arg;
		logic          typed;
		frame_report_t want;
	} plan_row_t;

	// arg bit 8 selects a random frame body, otherwise arg[7:0] fills it
	localparam logic [15:0] RAND_BODY = 16'h0100;

	localparam frame_report_t NO_WANT = '0;
	localparam frame_report_t WANT_ZERO_PASS = '{1'b1, 16'h0000, 16'h0000, 16'h0000,
		32'h0000_0000, 16'h0000, 16'h0000, 16'd0, 1'b0};
	localparam frame_report_t WANT_ONES_FAIL = '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd1, 1'b0};
	localparam frame_report_t WANT_ZERO_WRAP = '{1'b0, 16'h0000, 16'h0000, 16'h0000,
		32'h0000_0000, 16'h0000, 16'h0000, 16'd0, 1'b1};
	localparam frame_report_t WANT_ONES_PASS = '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd1, 1'b0};

	localparam int PLAN_ROWS = 18;

	// directed frames, strays, restarts and limit changes
	plan_row_t plan [PLAN_ROWS] = '{
		'{ROW_STRAY, 16'd2,                  1'b0, NO_WANT},
		'{ROW_GOOD,  16'h0000,               1'b1, WANT_ZERO_PASS},
		'{ROW_BAD,   16'h00FF,               1'b1, WANT_ONES_FAIL},
		'{ROW_STRAY, 16'd3,                  1'b0, NO_WANT},
		'{ROW_CUT,   16'd7,                  1'b0, NO_WANT},
		'{ROW_GOOD,  RAND_BODY,              1'b0, NO_WANT},
		'{ROW_CUT,   16'(FRAME_BYTES - 1),   1'b0, NO_WANT},
		'{ROW_CUT,   16'(FRAME_BYTES - 2),   1'b0, NO_WANT},
		'{ROW_BAD,   RAND_BODY,              1'b0, NO_WANT},
		'{ROW_LIMIT, 16'd1,                  1'b0, NO_WANT},
		'{ROW_BAD,   16'h0000,               1'b1, WANT_ZERO_WRAP},
		'{ROW_GOOD,  RAND_BODY,              1'b0, NO_WANT},
		'{ROW_LIMIT, 16'd0,                  1'b0, NO_WANT},
		'{ROW_BAD,   RAND_BODY,              1'b0, NO_WANT},
		'{ROW_LIMIT, 16'hFFFF,               1'b0, NO_WANT},
		'{ROW_BAD,   RAND_BODY,              1'b0, NO_WANT},
		'{ROW_GOOD,  16'h00FF,               1'b1, WANT_ONES_PASS},
		'{ROW_STRAY, 16'd2,                  1'b0, NO_WANT}
	};

	logic clk = 1'b0;
	logic arst_n;

	tfc_rx_if  byte_ch ();
	tfc_res_if report_ch ();
	tfc_cfg_if limit_ch ();

	telemetry_frame_fletcher_checker #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (byte_ch),
		.res   (report_ch),
		.cfg   (limit_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver model of the telemetry frame state
	logic [5:0]         rx_pos     = '0;
	logic [7:0]         sum_a      = '0;
	logic [7:0]         sum_b      = '0;
	logic [7:0]         field_mem [FIELD_BYTES];
	logic [7:0]         chk_lo     = '0;
	logic [COUNT_W-1:0] fails      = '0;
	logic               in_frame   = 1'b0;
	logic [COUNT_W-1:0] limit_now  = FAIL_LIMIT_RESET;

	frame_report_t reports_due [$];
	logic          use_typed = 1'b0;
	frame_report_t typed_want;

	int src_idle = 20;
	int snk_idle = 20;
	int hold_asks = 0;
	int body_bytes = 0;
	int mismatches = 0;
	int reports_seen = 0;
	int failed_seen = 0;
	int resyncs_seen = 0;
	logic [COUNT_W-1:0] last_limit;

	logic [7:0] frame_buf [FRAME_BYTES];

	// update the frame model with one accepted byte request
	task automatic take_byte(input logic [7:0] b, input logic st);
		frame_report_t r;
		logic [7:0]    hi;
		logic [7:0]    lo;
		logic [16:0]   nxt;
		if (st) begin
			rx_pos = '0;
			sum_a = '0;
			sum_b = '0;
			in_frame = 1'b1;
		end
		if (!in_frame)
			return;
		body_bytes++;
		if (rx_pos < CHECK_POS) begin
			sum_a = sum_a + b;
			sum_b = sum_b + sum_a;
			if (rx_pos < FIELD_BYTES)
				field_mem[rx_pos[3:0]] = b;
			rx_pos = rx_pos + 6'd1;
		end else if (rx_pos == CHECK_POS) begin
			chk_lo = b;
			rx_pos = rx_pos + 6'd1;
		end else begin
			hi = sum_a - sum_b;
			lo = sum_b - {sum_a[6:0], 1'b0};
			r.check_ok = ({hi, lo} == {b, chk_lo});
			r.resync_request = 1'b0;
			if (!r.check_ok) begin
				nxt = {1'b0, fails} + 17'd1;
				if (nxt >= {1'b0, limit_now}) begin
					fails = '0;
					r.resync_request = 1'b1;
				end else begin
					fails = nxt[15:0];
				end
			end
			r.voltage_raw     = {field_mem[1], field_mem[0]};
			r.temperature_raw = {field_mem[3], field_mem[2]};
			r.current_raw     = {field_mem[5], field_mem[4]};
			r.erpm_raw        = {field_mem[11], field_mem[10], field_mem[9], field_mem[8]};
			r.input_pwm_raw   = {field_mem[13], field_mem[12]};
			r.output_pwm_raw  = {field_mem[15], field_mem[14]};
			r.fail_count      = fails;
			in_frame = 1'b0;
			rx_pos = '0;
			if (use_typed) begin
				reports_due.push_back(typed_want);
				use_typed = 1'b0;
			end else begin
				reports_due.push_back(r);
			end
		end
	endtask

	// offer one byte, with random idle cycles before it
	task automatic send_byte(input logic [7:0] b, input logic st);
		while ($urandom_range(99) < src_idle) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.byte_value  <= b;
		byte_ch.frame_start <= st;
		do @(posedge clk); while (!byte_ch.ready);
		take_byte(b, st);
		@(negedge clk);
	endtask

	// frame body plus check word, flipped by a mask for bad frames
	task automatic build_frame(input logic rand_body, input logic [7:0] fill,
			input logic [15:0] flip);
		logic [7:0]  s1;
		logic [7:0]  s2;
		logic [15:0] word;
		s1 = '0;
		s2 = '0;
		for (int i = 0; i < CHECK_POS; i++) begin
			frame_buf[i] = rand_body ? 8'($urandom) : fill;
			s1 = s1 + frame_buf[i];
			s2 = s2 + s1;
		end
		word = {8'(s1 - s2), 8'(s2 - {s1[6:0], 1'b0})} ^ flip;
		frame_buf[CHECK_POS]     = word[7:0];
		frame_buf[CHECK_POS + 1] = word[15:8];
	endtask

	task automatic send_frame(input int n);
		for (int i = 0; i < n; i++)
			send_byte(frame_buf[i], i == 0);
	endtask

	// stop offering until every report is back and the pipeline is empty
	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (reports_due.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_limit(input logic [COUNT_W-1:0] v);
		limit_ch.valid <= 1'b1;
		limit_ch.data  <= v;
		do @(posedge clk); while (!limit_ch.ready);
		limit_now = v;
		last_limit = v;
		@(negedge clk);
		limit_ch.valid <= 1'b0;
	endtask

	// mostly well-formed frames, some strays, cut frames and noise
	task automatic run_phase(input int budget, input int stress);
		int   target;
		int   pick;
		int   n;
		logic stressed;
		target = body_bytes + budget;
		stressed = 1'b0;
		while (body_bytes < target) begin
			if (!stressed && body_bytes > target - budget / 2) begin
				stressed = 1'b1;
				if (stress == 1)
					hold_asks++;
				else if (stress == 2)
					settle();
			end
			pick = $urandom_range(99);
			if (pick < 70) begin
				build_frame($urandom_range(9) != 0, $urandom_range(1) ? 8'hFF : 8'h00,
					($urandom_range(4) < 2) ? 16'($urandom_range(65535, 1)) : 16'h0000);
				send_frame(FRAME_BYTES);
			end else if (pick < 80) begin
				n = $urandom_range(4, 1);
				repeat (n) send_byte(8'($urandom), 1'b0);
			end else if (pick < 92) begin
				build_frame(1'b1, 8'h00, 16'h0000);
				send_frame($urandom_range(FRAME_BYTES - 1, 1));
			end else begin
				n = $urandom_range(6, 1);
				repeat (n) send_byte(8'($urandom), $urandom_range(3) == 0);
			end
		end
	endtask

	// receiver side: random ready, plus a long hold when asked
	initial begin : sink_side
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		report_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				report_ch.ready <= 1'b0;
			end else begin
				report_ch.ready <= ($urandom_range(99) >= snk_idle);
			end
		end
	end

	task automatic report_mismatch(input frame_report_t want, input frame_report_t got,
			input logic orphan);
		mismatches++;
		if (mismatches <= 10) begin
			if (orphan)
				$display("%0t: report with nothing due", $time);
			else
				$display("%0t: want ok=%0b v=%h t=%h c=%h e=%h pi=%h po=%h n=%0d rs=%0b",
					$time, want.check_ok, want.voltage_raw, want.temperature_raw,
					want.current_raw, want.erpm_raw, want.input_pwm_raw,
					want.output_pwm_raw, want.fail_count, want.resync_request);
			$display("%0t:  got ok=%0b v=%h t=%h c=%h e=%h pi=%h po=%h n=%0d rs=%0b",
				$time, got.check_ok, got.voltage_raw, got.temperature_raw,
				got.current_raw, got.erpm_raw, got.input_pwm_raw,
				got.output_pwm_raw, got.fail_count, got.resync_request);
		end
	endtask

	// compare each accepted report with the oldest one due
	frame_report_t got_report;
	frame_report_t due_report;

	always @(posedge clk) begin
		if (arst_n && report_ch.valid && report_ch.ready) begin
			got_report = '{report_ch.check_ok, report_ch.voltage_raw,
				report_ch.temperature_raw, report_ch.current_raw, report_ch.erpm_raw,
				report_ch.input_pwm_raw, report_ch.output_pwm_raw,
				report_ch.fail_count, report_ch.resync_request};
			reports_seen++;
			if (!got_report.check_ok)
				failed_seen++;
			if (got_report.resync_request)
				resyncs_seen++;
			if (reports_due.size() == 0) begin
				report_mismatch(NO_WANT, got_report, 1'b1);
			end else begin
				due_report = reports_due.pop_front();
				if (got_report.check_ok !== due_report.check_ok
						|| got_report.voltage_raw !== due_report.voltage_raw
						|| got_report.temperature_raw !== due_report.temperature_raw
						|| got_report.current_raw !== due_report.current_raw
						|| got_report.erpm_raw !== due_report.erpm_raw
						|| got_report.input_pwm_raw !== due_report.input_pwm_raw
						|| got_report.output_pwm_raw !== due_report.output_pwm_raw
						|| got_report.fail_count !== due_report.fail_count
						|| got_report.resync_request !== due_report.resync_request)
					report_mismatch(due_report, got_report, 1'b0);
			end
		end
	end

	// run guard
	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// main sequence
	initial begin
		byte_ch.valid       <= 1'b0;
		byte_ch.byte_value  <= '0;
		byte_ch.frame_start <= 1'b0;
		limit_ch.valid      <= 1'b0;
		limit_ch.data       <= '0;
		arst_n = 1'b0;
		last_limit = FAIL_LIMIT_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part
		for (int r = 0; r < PLAN_ROWS; r++) begin
			case (plan[r].kind)
				ROW_GOOD, ROW_BAD: begin
					build_frame(plan[r].arg[8], plan[r].arg[7:0],
						(plan[r].kind != ROW_BAD) ? 16'h0000 :
						plan[r].arg[8] ? 16'($urandom_range(65535, 1)) : 16'h0001);
					use_typed = plan[r].typed;
					typed_want = plan[r].want;
					send_frame(FRAME_BYTES);
				end
				ROW_CUT: begin
					build_frame(1'b1, 8'h00, 16'h0000);
					send_frame(plan[r].arg);
				end
				ROW_STRAY: begin
					repeat (plan[r].arg) send_byte(8'($urandom), 1'b0);
				end
				ROW_LIMIT: begin
					settle();
					set_limit(plan[r].arg);
				end
				default: ;
			endcase
		end
		settle();

		// random part, three idling patterns and limits
		src_idle = 36;
		snk_idle = 81;
		run_phase(200, 1);
		settle();
		set_limit(16'd3);
		src_idle = 81;
		snk_idle = 36;
		run_phase(200, 2);
		settle();
		set_limit(16'($urandom_range(9, 2)));
		src_idle = 0;
		snk_idle = 0;
		run_phase(210, 0);
		settle();

		$display("covered %0d frame bytes, %0d reports, %0d failing checks, %0d resyncs",
			body_bytes, reports_seen, failed_seen, resyncs_seen);
		$display("fail limits 1000, 1, 0, 65535, 3 and %0d; long receiver hold and pauses",
			last_limit);
		if (mismatches == 0 && reports_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### telemetry_frame_fletcher_checker.f
rtl/core/tfc_pkg.sv
rtl/core/tfc_rx_if.sv
rtl/core/tfc_res_if.sv
rtl/core/tfc_cfg_if.sv
rtl/core/telemetry_frame_fletcher_checker.sv
rtl/core/tfc_checker.sv
tb/telemetry_frame_fletcher_checker_tb.sv
